### rtl/counting_semaphore_fifo_waiters_assert.svh
// Assertion macros for the counting semaphore block.
// Included by the RTL modules that check their own logic; no other dependency.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSFW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CSFW_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CSFW_ASSERT(label, prop, msg)
`define CSFW_ASSERT_NXT(label, pre, post, msg)
`endif
`endif

### rtl/csfw_pkg.sv
// Shared constants, types and helpers for the counting semaphore block.
// No dependencies; imported by the top level.
package csfw_pkg;

  localparam int WAIT_DEPTH = 16;
  localparam int ID_BITS    = 8;
  localparam int PTR_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int TOT_W      = $clog2(WAIT_DEPTH + 1);

  localparam int CNT_W       = 16;
  localparam int NOW_W       = 17;
  localparam int WID_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [TOT_W-1:0]   tot_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [3:0]         status_t;
  typedef logic [2:0]         mode_t;

  localparam mode_t M_POST    = 3'd0;
  localparam mode_t M_WAIT    = 3'd1;
  localparam mode_t M_TRYWAIT = 3'd2;
  localparam mode_t M_CANCEL  = 3'd3;
  localparam mode_t M_FREEZE  = 3'd4;
  localparam mode_t M_THAW    = 3'd5;

  localparam status_t ST_OK         = 4'd0;
  localparam status_t ST_QUEUED     = 4'd1;
  localparam status_t ST_NO_UNIT    = 4'd2;
  localparam status_t ST_FROZEN     = 4'd3;
  localparam status_t ST_RANGE      = 4'd4;
  localparam status_t ST_ALREADY    = 4'd5;
  localparam status_t ST_NOT_FROZEN = 4'd6;
  localparam status_t ST_FULL       = 4'd7;
  localparam status_t ST_NOT_FOUND  = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNT = 1'd1;

  // Map a queue position to a RAM address, wrapping at the queue depth.
  function automatic ptr_t qaddr(ptr_t base, ptr_t off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PTR_W + 1)'(WAIT_DEPTH)) begin
      sum = sum - (PTR_W + 1)'(WAIT_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

### rtl/csfw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/counting_semaphore_fifo_waiters.sv
// Counting semaphore with an ordered queue of waiter IDs.
// Depends on csfw_pkg, csfw_ram and counting_semaphore_fifo_waiters_assert.svh.
//
// Usage: one request transaction on in_* (mode, waiter_id) yields one result
// transaction on out_* (status, count, availability, woken waiter). The
// user must write count_max or initial_count on the cfg_* port only while
// the block is idle; the block itself does not enforce this. The count,
// frozen flag and queue length sit in registers; the waiter IDs sit in a
// circular queue held in a one-port-read RAM with registered read data.
// Steps: a request is taken in the idle state, executed, then its result is
// registered in the done state; a post that wakes a waiter reads the queue
// head between execute and done. A cancel reads the queue one entry per
// cycle until it finds the ID, then closes the gap one entry per cycle.
// One request is in work at a time; the next is taken once the previous
// result sits in the output register. Reset sets count 0, not frozen,
// queue empty, count_max 1; no RAM clearing. When the receiver stalls, the
// result holds in the output register and the block finishes its current
// request, then waits for the register to drain.
`include "counting_semaphore_fifo_waiters_assert.svh"
module counting_semaphore_fifo_waiters (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [2:0] mode, [10:3] waiter_id, [15:11] zero
  input  logic [csfw_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [3:0] status, [20:4] count_now, [21] available, [22] woken_valid,
  // [30:23] woken_id, [31] zero
  output logic [csfw_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_we,
  input  logic [csfw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [csfw_pkg::CNT_W-1:0]           cfg_wdata
);
  import csfw_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_POSTRD = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]             state_r, state_nxt;
  mode_t                  mode_r, mode_nxt;
  id_t                    id_r, id_nxt;
  cnt_t                   count_max_r, count_max_nxt;
  cnt_t                   unit_r, unit_nxt;
  logic                   frozen_r, frozen_nxt;
  ptr_t                   head_r, head_nxt;
  tot_t                   total_r, total_nxt;
  ptr_t                   idx_r, idx_nxt;
  status_t                status_r, status_nxt;
  logic                   wvalid_r, wvalid_nxt;
  logic [WID_W-1:0]       wid_r, wid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                   ram_we;
  ptr_t                   ram_waddr;
  id_t                    ram_wdata;
  ptr_t                   ram_raddr;
  id_t                    ram_rdata;
  logic [NOW_W-1:0]       count_now;
  logic                   avail;

  csfw_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(WAIT_DEPTH)
  ) u_waiters (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign count_now  = frozen_r ? '1 : {1'b0, unit_r};
  assign avail      = !frozen_r && (unit_r != '0);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    id_nxt        = id_r;
    count_max_nxt = count_max_r;
    unit_nxt      = unit_r;
    frozen_nxt    = frozen_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    wvalid_nxt    = wvalid_r;
    wid_nxt       = wid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_wdata     = id_r;
    ram_raddr     = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tdata[2:0];
          id_nxt    = in_tdata[3 +: ID_BITS];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        wvalid_nxt = 1'b0;
        wid_nxt    = '0;
        state_nxt  = S_DONE;
        unique case (mode_r)
          M_POST: begin
            if (frozen_r) begin
              status_nxt = ST_FROZEN;
            end else if (total_r != '0) begin
              ram_raddr = head_r;
              state_nxt = S_POSTRD;
            end else if (unit_r >= count_max_r) begin
              status_nxt = ST_RANGE;
            end else begin
              unit_nxt = unit_r + 1'b1;
            end
          end
          M_WAIT: begin
            if (!frozen_r && (unit_r != '0)) begin
              unit_nxt = unit_r - 1'b1;
            end else if (total_r >= TOT_W'(WAIT_DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = qaddr(head_r, total_r[PTR_W-1:0]);
              ram_wdata  = id_r;
              total_nxt  = total_r + 1'b1;
              status_nxt = ST_QUEUED;
            end
          end
          M_TRYWAIT: begin
            if (!frozen_r && (unit_r != '0)) begin
              unit_nxt = unit_r - 1'b1;
            end else begin
              status_nxt = ST_NO_UNIT;
            end
          end
          M_CANCEL: begin
            if (total_r == '0) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              idx_nxt   = '0;
              ram_raddr = head_r;
              state_nxt = S_SCAN;
            end
          end
          M_FREEZE: begin
            if (frozen_r) begin
              status_nxt = ST_ALREADY;
            end else begin
              frozen_nxt = 1'b1;
              unit_nxt   = '0;
            end
          end
          M_THAW: begin
            if (!frozen_r) begin
              status_nxt = ST_NOT_FROZEN;
            end else begin
              frozen_nxt = 1'b0;
              unit_nxt   = '0;
              total_nxt  = '0;
              head_nxt   = '0;
            end
          end
          default: begin
          end
        endcase
      end
      S_POSTRD: begin
        wvalid_nxt = 1'b1;
        wid_nxt    = WID_W'(ram_rdata);
        head_nxt   = qaddr(head_r, PTR_W'(1));
        total_nxt  = total_r - 1'b1;
        state_nxt  = S_DONE;
      end
      S_SCAN: begin
        if (ram_rdata == id_r) begin
          if (TOT_W'(idx_r) + 1'b1 == total_r) begin
            total_nxt = total_r - 1'b1;
            state_nxt = S_DONE;
          end else begin
            ram_raddr = qaddr(head_r, idx_r + 1'b1);
            state_nxt = S_SHIFT;
          end
        end else if (TOT_W'(idx_r) + 1'b1 == total_r) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = qaddr(head_r, idx_r + 1'b1);
        end
      end
      S_SHIFT: begin
        // move the entry behind the gap one place toward the head
        ram_we    = 1'b1;
        ram_waddr = qaddr(head_r, idx_r);
        ram_wdata = ram_rdata;
        if (TOT_W'(idx_r) + TOT_W'(2) == total_r) begin
          total_nxt = total_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = qaddr(head_r, idx_r + PTR_W'(2));
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, wid_r, wvalid_r, avail, count_now, status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNT_MAX: begin
          count_max_nxt = cfg_wdata;
        end
        REG_INIT_COUNT: begin
          unit_nxt   = (cfg_wdata > count_max_r) ? count_max_r : cfg_wdata;
          frozen_nxt = 1'b0;
          total_nxt  = '0;
          head_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_max_r <= CNT_W'(1);
      unit_r      <= '0;
      frozen_r    <= 1'b0;
      head_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_max_r <= count_max_nxt;
      unit_r      <= unit_nxt;
      frozen_r    <= frozen_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    id_r       <= id_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    wvalid_r   <= wvalid_nxt;
    wid_r      <= wid_nxt;
    out_data_r <= out_data_nxt;
  end

  `CSFW_ASSERT(a_total_bound, total_r <= TOT_W'(WAIT_DEPTH), "waiter total above depth")
  `CSFW_ASSERT(a_frozen_zero, !frozen_r || (unit_r == '0), "count nonzero while frozen")
  `CSFW_ASSERT(a_woken_ok, !(out_valid_r && out_data_r[22]) || (out_data_r[3:0] == ST_OK), "wake without ok status")
  `CSFW_ASSERT(a_scan_range, !((state_r == S_SCAN) || (state_r == S_SHIFT)) || (TOT_W'(idx_r) < total_r), "scan index past queue end")
  `CSFW_ASSERT_NXT(a_done_push, (state_r == S_DONE) && (!out_valid_r || out_tready), out_valid_r && (state_r == S_IDLE), "result not pushed")

endmodule

### sim/tb.sv
// Testbench for counting_semaphore_fifo_waiters: request/result streams checked against
// a transaction-level predictor of the count, frozen flag and waiter queue.
// Depends on csfw_pkg and the RTL top level only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csfw_pkg::*;

  localparam mode_t M_QUERY = 3'd6;
  localparam mode_t M_SPARE = 3'd7;
  localparam logic [NOW_W-1:0] NOW_FROZEN = '1;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * WAIT_DEPTH + 8;

  typedef enum int {PROF_MIXED, PROF_FILL, PROF_DRAIN} profile_e;

  typedef struct packed {
    status_t          status;
    logic [NOW_W-1:0] count_now;
    logic             available;
    logic             woken_valid;
    id_t              woken_id;
  } sem_result_t;

  class sem_tracker;
    cnt_t        cnt_max;
    cnt_t        unit_cnt;
    bit          frozen;
    id_t         waiters[$];
    sem_result_t pending_results[$];
    int          mismatches;
    int          n_checked;
    int          n_woken;
    int          n_full;

    function new();
      cnt_max  = 1;
      unit_cnt = 0;
      frozen   = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, cnt_t val);
      if (idx == REG_COUNT_MAX) begin
        cnt_max = val;
      end else begin
        unit_cnt = (val > cnt_max) ? cnt_max : val;
        frozen   = 0;
        waiters.delete();
      end
    endfunction

    function void note_request(mode_t mode, id_t id);
      sem_result_t r;
      int          pos;
      r   = '0;
      pos = -1;
      r.status = ST_OK;
      case (mode)
        M_POST: begin
          if (frozen) begin
            r.status = ST_FROZEN;
          end else if (waiters.size() > 0) begin
            r.woken_valid = 1'b1;
            r.woken_id    = waiters.pop_front();
            n_woken++;
          end else if (unit_cnt >= cnt_max) begin
            r.status = ST_RANGE;
          end else begin
            unit_cnt++;
          end
        end
        M_WAIT: begin
          if (!frozen && unit_cnt != 0) begin
            unit_cnt--;
          end else if (waiters.size() >= WAIT_DEPTH) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            waiters.push_back(id);
            r.status = ST_QUEUED;
          end
        end
        M_TRYWAIT: begin
          if (!frozen && unit_cnt != 0) unit_cnt--;
          else r.status = ST_NO_UNIT;
        end
        M_CANCEL: begin
          r.status = ST_NOT_FOUND;
          foreach (waiters[i]) if (pos < 0 && waiters[i] == id) pos = i;
          if (pos >= 0) begin
            waiters.delete(pos);
            r.status = ST_OK;
          end
        end
        M_FREEZE: begin
          if (frozen) begin
            r.status = ST_ALREADY;
          end else begin
            frozen   = 1;
            unit_cnt = 0;
          end
        end
        M_THAW: begin
          if (!frozen) begin
            r.status = ST_NOT_FROZEN;
          end else begin
            frozen   = 0;
            unit_cnt = 0;
            waiters.delete();
          end
        end
        default: ;
      endcase
      r.count_now = frozen ? NOW_FROZEN : {1'b0, unit_cnt};
      r.available = !frozen && unit_cnt != 0;
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 100)
        $display("MISMATCH on result %0d, %s: got 0x%0h, want 0x%0h", n_checked, what, got, want);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] d);
      sem_result_t w;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", d, 0);
        return;
      end
      w = pending_results.pop_front();
      if (d[3:0] != w.status) report_mismatch("status", d[3:0], w.status);
      if (d[20:4] != w.count_now) report_mismatch("count_now", d[20:4], w.count_now);
      if (d[21] != w.available) report_mismatch("available", d[21], w.available);
      if (d[22] != w.woken_valid) report_mismatch("woken_valid", d[22], w.woken_valid);
      if (d[30:23] != w.woken_id) report_mismatch("woken_id", d[30:23], w.woken_id);
      n_checked++;
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  cnt_t                   cfg_wdata = '0;

  sem_tracker sb = new();
  bit         quiet = 1'b0;
  int         ready_hold = 0;
  int         stall_cycles = 0;
  int         n_sent = 0;
  int         n_settings = 0;

  counting_semaphore_fifo_waiters u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    else if (r < 90) return $urandom_range(3, 1);
    else if (r < 97) return $urandom_range(12, 4);
    else return $urandom_range(60, 20);
  endfunction

  function automatic mode_t pick_mode(profile_e p);
    int w[8];
    int r;
    int acc;
    case (p)
      PROF_FILL:  w = '{10, 50, 8, 15, 3, 4, 5, 5};
      PROF_DRAIN: w = '{45, 18, 15, 10, 3, 4, 3, 2};
      default:    w = '{26, 26, 10, 16, 5, 7, 5, 5};
    endcase
    r   = $urandom_range(99);
    acc = 0;
    for (int i = 0; i < 8; i++) begin
      acc += w[i];
      if (r < acc) return mode_t'(i);
    end
    return M_QUERY;
  endfunction

  function automatic id_t pick_id(mode_t m, bit small_ids);
    if (m == M_CANCEL && sb.waiters.size() > 0 && $urandom_range(3) != 0)
      return sb.waiters[$urandom_range(sb.waiters.size() - 1)];
    if (small_ids) return id_t'($urandom_range(3));
    return id_t'($urandom_range(255));
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(3) != 0);
      ready_hold <= idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(mode_t mode, id_t id);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - ID_BITS - 3){1'b0}}, id, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(mode, id);
    n_sent++;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(bit wr_max, cnt_t max_val, bit wr_init, cnt_t init_val);
    if (wr_max) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_COUNT_MAX;
      cfg_wdata <= max_val;
      @(posedge clk);
      sb.load_reg(REG_COUNT_MAX, max_val);
    end
    if (wr_init) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_INIT_COUNT;
      cfg_wdata <= init_val;
      @(posedge clk);
      sb.load_reg(REG_INIT_COUNT, init_val);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  task automatic run_directed();
    send_request(M_TRYWAIT, 8'h00);
    send_request(M_POST, 8'h00);
    send_request(M_POST, 8'hFF);
    send_request(M_WAIT, 8'h12);
    send_request(M_WAIT, 8'hFF);
    send_request(M_WAIT, 8'hAA);
    send_request(M_WAIT, 8'hAA);
    for (int i = 1; i <= 13; i++) send_request(M_WAIT, id_t'(i));
    send_request(M_WAIT, 8'h80);
    send_request(M_CANCEL, 8'hAA);
    send_request(M_CANCEL, 8'h33);
    send_request(M_POST, 8'h55);
    send_request(M_FREEZE, 8'h00);
    send_request(M_FREEZE, 8'hFF);
    send_request(M_POST, 8'h00);
    send_request(M_TRYWAIT, 8'h00);
    send_request(M_WAIT, 8'h7F);
    send_request(M_THAW, 8'h00);
    send_request(M_THAW, 8'h00);
    send_request(M_QUERY, 8'hFF);
    send_request(M_SPARE, 8'h00);
    send_request(M_CANCEL, 8'h00);
  endtask

  task automatic run_random(int n, profile_e prof, bit small_ids);
    mode_t m;
    id_t   id;
    for (int k = 0; k < n; k++) begin
      if (k % 150 == 75) wait_drained();
      m  = pick_mode(prof);
      id = pick_id(m, small_ids);
      send_request(m, id);
    end
  endtask

  initial begin
    cnt_t mx;
    cnt_t ini;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(1'b1, 16'd1, 1'b1, 16'd0);
    run_directed();
    wait_drained();

    configure(1'b1, 16'd0, 1'b1, 16'd0);
    run_random(260, PROF_FILL, 1'b1);
    wait_drained();
    configure(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
    run_random(200, PROF_DRAIN, 1'b0);
    wait_drained();
    configure(1'b0, 16'd0, 1'b1, 16'hFFFE);
    run_random(150, PROF_MIXED, 1'b0);
    wait_drained();
    configure(1'b1, 16'd3, 1'b1, 16'd5);
    run_random(260, PROF_MIXED, 1'b1);
    wait_drained();
    configure(1'b1, 16'd1000, 1'b1, 16'd500);
    configure(1'b1, 16'd10, 1'b0, 16'd0);
    run_random(120, PROF_DRAIN, 1'b0);
    wait_drained();

    quiet <= 1'b1;
    configure(1'b1, 16'd2, 1'b1, 16'd1);
    run_random(200, PROF_MIXED, 1'b1);
    wait_drained();
    quiet <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      mx  = ($urandom_range(1) != 0) ? cnt_t'($urandom_range(20)) : cnt_t'($urandom_range(65535));
      ini = ($urandom_range(1) != 0) ? cnt_t'($urandom_range(20)) : cnt_t'($urandom_range(65535));
      configure(1'b1, mx, 1'b1, ini);
      run_random(190, profile_e'(p % 3), p[0]);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d requests across %0d register settings",
             sb.n_checked, n_sent, n_settings);
    $display("Waiters woken by post: %0d, waits refused on a full queue: %0d",
             sb.n_woken, sb.n_full);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/csfw_pkg.sv
rtl/csfw_ram.sv
rtl/counting_semaphore_fifo_waiters.sv
sim/tb.sv
